@@ design/quaternion_kinematic_derivative_defines.svh @@
// ----------------------------------------------------------------------------
// Quaternion kinematic derivative assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_KINEMATIC_DERIVATIVE_DEFINES_SVH
`define QUATERNION_KINEMATIC_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define QKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

@@ design/qkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion kinematic derivative package
// Fixed-point types, term tables and the output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package qkd_pkg;

  localparam int unsigned GAIN_W = 24;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [51:0] rsum_t;
  typedef logic signed [35:0] nerr_t;
  typedef logic signed [34:0] gerr_t;
  typedef logic signed [48:0] corr_t;
  typedef logic signed [53:0] comb_t;
  typedef logic signed [36:0] rnd_t;
  typedef logic [1:0] idx2_t;

  typedef struct packed {
    logic sat;
    word_t val;
  } clamp_t;

  localparam nerr_t ONE_Q30    = 36'sh0_4000_0000;
  localparam comb_t ROUND_HALF = 54'sh1_0000;
  localparam word_t WORD_MAX   = 32'sh7fff_ffff;
  localparam word_t WORD_MIN   = 32'sh8000_0000;

  // Rate matrix rows: quaternion component, rate axis (0 p, 1 q, 2 r), subtract flag.
  localparam idx2_t QIDX [4][3] = '{
    '{2'd3, 2'd2, 2'd1},
    '{2'd3, 2'd2, 2'd0},
    '{2'd1, 2'd0, 2'd3},
    '{2'd2, 2'd0, 2'd1}
  };
  localparam idx2_t RIDX [4][3] = '{
    '{2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1}
  };
  localparam logic RNEG [4][3] = '{
    '{1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b1}
  };

  function automatic clamp_t clamp32(input rnd_t v);
    clamp_t res;
    if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111)) begin
      res.sat = 1'b0;
      res.val = v[31:0];
    end else begin
      res.sat = 1'b1;
      res.val = v[36] ? WORD_MIN : WORD_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/qkd_datapath.sv @@
// ----------------------------------------------------------------------------
// Quaternion kinematic derivative datapath
// Five register stages: products, row sums and norm error, gain product,
// correction product, then combine, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module qkd_datapath (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire qkd_pkg::word_t             quat [4],
  input  wire qkd_pkg::word_t             rate [3],
  input  wire logic [qkd_pkg::GAIN_W-1:0] norm_gain,
  output qkd_pkg::word_t                  deriv [4],
  output logic                            saturated
);

  qkd_pkg::word_t s1_q_r [4];
  qkd_pkg::prod_t s1_prod_r [4][3];
  qkd_pkg::prod_t s1_sq_r [4];

  qkd_pkg::word_t s2_q_r [4];
  qkd_pkg::rsum_t s2_s_r [4];
  qkd_pkg::nerr_t s2_eps_r;
  qkd_pkg::rsum_t s2_s_nxt [4];
  qkd_pkg::nerr_t s2_eps_nxt;

  qkd_pkg::word_t s3_q_r [4];
  qkd_pkg::rsum_t s3_s_r [4];
  qkd_pkg::gerr_t s3_g_r;
  logic signed [60:0] s3_gprod_nxt;

  qkd_pkg::rsum_t s4_s_r [4];
  qkd_pkg::corr_t s4_c_r [4];
  logic signed [66:0] s4_cprod_nxt [4];

  qkd_pkg::word_t s5_d_r [4];
  logic           s5_sat_r;
  qkd_pkg::clamp_t s5_cl_nxt [4];
  logic           s5_sat_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_q_r[i]  <= quat[i];
        s1_sq_r[i] <= qkd_pkg::prod_t'(quat[i]) * qkd_pkg::prod_t'(quat[i]);
        for (int j = 0; j < 3; j++) begin
          s1_prod_r[i][j] <= qkd_pkg::prod_t'(quat[qkd_pkg::QIDX[i][j]]) *
                             qkd_pkg::prod_t'(rate[qkd_pkg::RIDX[i][j]]);
        end
      end
    end
  end

  always_comb begin
    qkd_pkg::nerr_t nsum;
    nsum = '0;
    for (int i = 0; i < 4; i++) begin
      s2_s_nxt[i] = qkd_pkg::rsum_t'($signed(s1_prod_r[i][0][63:14]));
      for (int j = 1; j < 3; j++) begin
        if (qkd_pkg::RNEG[i][j]) begin
          s2_s_nxt[i] = s2_s_nxt[i] - qkd_pkg::rsum_t'($signed(s1_prod_r[i][j][63:14]));
        end else begin
          s2_s_nxt[i] = s2_s_nxt[i] + qkd_pkg::rsum_t'($signed(s1_prod_r[i][j][63:14]));
        end
      end
      nsum = nsum + qkd_pkg::nerr_t'($signed(s1_sq_r[i][63:30]));
    end
    s2_eps_nxt = qkd_pkg::ONE_Q30 - nsum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q_r   <= s1_q_r;
      s2_s_r   <= s2_s_nxt;
      s2_eps_r <= s2_eps_nxt;
    end
  end

  assign s3_gprod_nxt = $signed({{37{1'b0}}, norm_gain}) *
                        $signed({{25{s2_eps_r[35]}}, s2_eps_r});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q_r <= s2_q_r;
      s3_s_r <= s2_s_r;
      s3_g_r <= s3_gprod_nxt[60:26];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s4_cprod_nxt[i] = $signed({{32{s3_g_r[34]}}, s3_g_r}) *
                        $signed({{35{s3_q_r[i][31]}}, s3_q_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s_r <= s3_s_r;
      for (int i = 0; i < 4; i++) begin
        s4_c_r[i] <= s4_cprod_nxt[i][66:18];
      end
    end
  end

  always_comb begin
    qkd_pkg::comb_t x;
    qkd_pkg::comb_t rnd;
    s5_sat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      x   = (qkd_pkg::comb_t'(s4_c_r[i]) <<< 1) - qkd_pkg::comb_t'(s4_s_r[i]);
      rnd = x + qkd_pkg::ROUND_HALF;
      s5_cl_nxt[i] = qkd_pkg::clamp32(rnd[53:17]);
      s5_sat_nxt = s5_sat_nxt | s5_cl_nxt[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s5_d_r[i] <= s5_cl_nxt[i].val;
      end
      s5_sat_r <= s5_sat_nxt;
    end
  end

  assign deriv     = s5_d_r;
  assign saturated = s5_sat_r;

endmodule

`default_nettype wire

@@ design/quaternion_kinematic_derivative.sv @@
// ----------------------------------------------------------------------------
// Quaternion kinematic derivative
// Quaternion rate from body rates with optional unit-norm correction.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// passes it through the five register stages of the arithmetic pipeline,
// which advance together whenever the output register is empty or its item
// is being taken, so in_tready follows out_tready combinationally. The gain
// register, read by the third stage, is written via cfg_we and cfg_wdata;
// the user must write only while no item is in flight (block does not check).
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_kinematic_derivative (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [qkd_pkg::GAIN_W-1:0] cfg_wdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // quat_scalar, quat_x, quat_y, quat_z, rate_roll, rate_pitch, rate_yaw
  input  wire logic [223:0]               in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // deriv_scalar, deriv_x, deriv_y, deriv_z
  output logic [127:0]                    out_tdata,
  // saturated
  output logic [0:0]                      out_tuser
);

  logic [qkd_pkg::GAIN_W-1:0] gain_r;
  logic [4:0]                 vld_r;
  logic                       adv;
  qkd_pkg::word_t             quat [4];
  qkd_pkg::word_t             rate [3];
  qkd_pkg::word_t             deriv [4];
  logic                       sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  assign adv = !vld_r[4] || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quat[i] = in_tdata[32*i +: 32];
    end
    for (int i = 0; i < 3; i++) begin
      rate[i] = in_tdata[128 + 32*i +: 32];
    end
  end

  qkd_datapath u_dp (
    .clk       (clk),
    .en        (adv),
    .quat      (quat),
    .rate      (rate),
    .norm_gain (gain_r),
    .deriv     (deriv),
    .saturated (sat)
  );

  assign in_tready  = adv;
  assign out_tvalid = vld_r[4];
  assign out_tdata  = {deriv[3], deriv[2], deriv[1], deriv[0]};
  assign out_tuser  = sat;

endmodule

`default_nettype wire

@@ design/qkd_checker.sv @@
// ----------------------------------------------------------------------------
// Quaternion kinematic derivative port checker
// Port-level assertions on flow control, latency and the clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_kinematic_derivative_defines.svh"

module qkd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  logic [3:0] clip_lane;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      clip_lane[i] = (out_tdata[32*i +: 32] == 32'h7fffffff) ||
                     (out_tdata[32*i +: 32] == 32'h80000000);
    end
  end

  `QKD_ASSERT_NOW(a_ready_flow, 1'b1, in_tready == (!out_tvalid || out_tready))

  `QKD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `QKD_ASSERT_NEXT(a_latency, (in_tvalid && in_tready) ##1 in_tready ##1 in_tready ##1 in_tready ##1 in_tready, out_tvalid)

  `QKD_ASSERT_NOW(a_sat_clip, out_tvalid && out_tuser[0], |clip_lane)

endmodule

bind quaternion_kinematic_derivative qkd_checker u_qkd_checker (.*);

`default_nettype wire
